@@ sv/activity_selection_macros.svh @@
// ----------------------------------------------------------------------------
// activity_selection_macros.svh
// Assertion shorthands used by the activity selection RTL.
// ----------------------------------------------------------------------------
`ifndef ACTIVITY_SELECTION_MACROS_SVH
`define ACTIVITY_SELECTION_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define ASEL_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define ASEL_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/asel_pkg.sv @@
// ----------------------------------------------------------------------------
// asel_pkg
// Types and constants shared by the activity selection block.
// ----------------------------------------------------------------------------
`default_nettype none

package asel_pkg;

  localparam int MAX_ACTIVITIES_DEF = 16;
  localparam int RESULT_LIMIT       = 16;
  localparam int SEL_CNT_W          = 5;
  localparam int TIME_W             = 16;
  localparam int FIN_W              = 17;
  localparam int POS_W              = 4;

  typedef struct packed {
    logic [TIME_W-1:0] start_time;
    logic [TIME_W-1:0] duration;
    logic              last_activity;
  } in_beat_t;

  typedef struct packed {
    logic [TIME_W-1:0] sel_start;
    logic [TIME_W-1:0] sel_duration;
    logic [FIN_W-1:0]  sel_finish;
    logic [POS_W-1:0]  sel_position;
    logic              end_of_run;
    logic              dropped_flag;
  } out_beat_t;

  // One stored activity; finish kept alongside to spare an adder per cell.
  typedef struct packed {
    logic [TIME_W-1:0] start;
    logic [TIME_W-1:0] len;
    logic [FIN_W-1:0]  fin;
  } act_entry_t;

  // Per-cycle command broadcast to every cell of the chain.
  typedef struct packed {
    logic ins;
    logic shift;
  } cell_ctrl_t;

  typedef enum logic {
    ST_LOAD,
    ST_SCAN
  } asel_state_t;

endpackage

`default_nettype wire

@@ sv/asel_cell.sv @@
// ----------------------------------------------------------------------------
// asel_cell
// One slot of the sorted activity chain: hold, take the new activity,
// take the left neighbor's entry on insert, or the right one's on scan.
// ----------------------------------------------------------------------------
`default_nettype none

module asel_cell
  import asel_pkg::*;
(
  input  wire logic       clk,
  input  wire cell_ctrl_t ctrl,
  input  wire logic       occupied,
  input  wire act_entry_t new_entry,
  input  wire logic       left_keep,
  input  wire act_entry_t left_entry,
  input  wire act_entry_t right_entry,
  output logic            keep,
  output act_entry_t      entry
);

  act_entry_t ent_r;
  act_entry_t ent_nxt;

  // Hold when this slot finishes no later than the arrival (ties stay ahead).
  assign keep  = occupied && (ent_r.fin <= new_entry.fin);
  assign entry = ent_r;

  always_comb begin
    ent_nxt = ent_r;
    if (ctrl.shift) begin
      ent_nxt = right_entry;
    end else if (ctrl.ins && !keep) begin
      ent_nxt = left_keep ? new_entry : left_entry;
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

endmodule

`default_nettype wire

@@ sv/activity_selection.sv @@
// ----------------------------------------------------------------------------
// activity_selection
// Greedy activity selection over a sorted insertion chain.
//
// Input channel (in_valid/in_stall/in_data): one activity per beat, a
// start time and a length. While loading, in_stall is low and a beat is
// taken every cycle; the activity drops into its finish-ordered slot of the
// cell chain in that same cycle. Beats past MAX_ACTIVITIES are dropped and
// flagged. A beat with last_activity set closes the set.
// After the closing beat the chain shifts toward cell 0 one entry a cycle
// while the output register is free; the greedy test runs on cell 0, and
// in_stall stays high for the whole scan.
// Result channel (out_valid/out_stall/out_data): one beat per chosen
// activity, in schedule order, the last marked end_of_run; at most 16 per
// run. A pick waits until the next pick or the scan end pushes it out.
// A stalled result holds in the output register and freezes the scan.
// Reset (rst_n low, synchronous) empties the chain and clears the drop flag.
// ----------------------------------------------------------------------------
`default_nettype none

module activity_selection
  import asel_pkg::*;
#(
  parameter int MAX_ACTIVITIES = MAX_ACTIVITIES_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_beat_t  in_data,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_beat_t      out_data
);

`include "activity_selection_macros.svh"

  localparam int CW = $clog2(MAX_ACTIVITIES + 1);

  // Control state
  asel_state_t          state_r, state_nxt;
  logic [CW-1:0]        count_r, count_nxt;
  logic [CW-1:0]        rem_r, rem_nxt;
  logic [SEL_CNT_W-1:0] sel_n_r, sel_n_nxt;
  logic                 ovf_r, ovf_nxt;
  logic                 held_v_r, held_v_nxt;
  logic                 out_valid_r, out_valid_nxt;

  // Payload state
  logic [FIN_W-1:0]     prev_fin_r, prev_fin_nxt;
  out_beat_t            held_r, held_nxt;
  out_beat_t            out_data_r, out_data_nxt;

  // Chain wiring
  cell_ctrl_t           ctrl;
  act_entry_t           new_entry;
  act_entry_t           ent   [MAX_ACTIVITIES];
  logic [MAX_ACTIVITIES-1:0] keep;
  logic [MAX_ACTIVITIES-1:0] occ;
  act_entry_t           head;
  logic                 out_free;
  logic                 scan_done;

  assign new_entry.start = in_data.start_time;
  assign new_entry.len   = in_data.duration;
  assign new_entry.fin   = {1'b0, in_data.start_time} + {1'b0, in_data.duration};
  assign head            = ent[0];

  genvar g;
  generate
    for (g = 0; g < MAX_ACTIVITIES; g++) begin : g_cell
      assign occ[g] = (CW'(g) < count_r);
      if (g == 0) begin : g_first
        asel_cell u_cell (
          .clk        (clk),
          .ctrl       (ctrl),
          .occupied   (occ[g]),
          .new_entry  (new_entry),
          .left_keep  (1'b1),
          .left_entry (new_entry),
          .right_entry(ent[g+1]),
          .keep       (keep[g]),
          .entry      (ent[g])
        );
      end else if (g == MAX_ACTIVITIES - 1) begin : g_last
        asel_cell u_cell (
          .clk        (clk),
          .ctrl       (ctrl),
          .occupied   (occ[g]),
          .new_entry  (new_entry),
          .left_keep  (keep[g-1]),
          .left_entry (ent[g-1]),
          .right_entry(ent[g]),
          .keep       (keep[g]),
          .entry      (ent[g])
        );
      end else begin : g_mid
        asel_cell u_cell (
          .clk        (clk),
          .ctrl       (ctrl),
          .occupied   (occ[g]),
          .new_entry  (new_entry),
          .left_keep  (keep[g-1]),
          .left_entry (ent[g-1]),
          .right_entry(ent[g+1]),
          .keep       (keep[g]),
          .entry      (ent[g])
        );
      end
    end
  endgenerate

  // The output register can take a new beat when empty or draining now.
  assign out_free  = !out_valid_r || !out_stall;
  // Scan ends when the chain is exhausted or the result budget is spent.
  assign scan_done = (rem_r == '0) || (sel_n_r == SEL_CNT_W'(RESULT_LIMIT));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      count_r     <= '0;
      rem_r       <= '0;
      sel_n_r     <= '0;
      ovf_r       <= 1'b0;
      held_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      rem_r       <= rem_nxt;
      sel_n_r     <= sel_n_nxt;
      ovf_r       <= ovf_nxt;
      held_v_r    <= held_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prev_fin_r <= prev_fin_nxt;
    held_r     <= held_nxt;
    out_data_r <= out_data_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    rem_nxt       = rem_r;
    sel_n_nxt     = sel_n_r;
    ovf_nxt       = ovf_r;
    held_v_nxt    = held_v_r;
    prev_fin_nxt  = prev_fin_r;
    held_nxt      = held_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    ctrl          = '0;
    in_stall      = 1'b1;

    unique case (state_r)
      ST_LOAD: begin
        in_stall = 1'b0;
        if (in_valid) begin
          // Insert while room remains, else drop and remember it.
          if (count_r < CW'(MAX_ACTIVITIES)) begin
            ctrl.ins  = 1'b1;
            count_nxt = count_r + CW'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_data.last_activity) begin
            state_nxt  = ST_SCAN;
            rem_nxt    = count_nxt;
            sel_n_nxt  = '0;
            held_v_nxt = 1'b0;
          end
        end
      end
      ST_SCAN: begin
        if (out_free) begin
          if (scan_done) begin
            // Release the held pick as the closing beat and empty the chain.
            if (held_v_r) begin
              out_valid_nxt             = 1'b1;
              out_data_nxt              = held_r;
              out_data_nxt.end_of_run   = 1'b1;
              out_data_nxt.dropped_flag = ovf_r;
            end
            held_v_nxt = 1'b0;
            count_nxt  = '0;
            ovf_nxt    = 1'b0;
            state_nxt  = ST_LOAD;
          end else begin
            ctrl.shift = 1'b1;
            rem_nxt    = rem_r - CW'(1);
            if ((sel_n_r == '0) || ({1'b0, head.start} >= prev_fin_r)) begin
              // A new pick pushes the previous one out; it is not the last.
              if (held_v_r) begin
                out_valid_nxt             = 1'b1;
                out_data_nxt              = held_r;
                out_data_nxt.end_of_run   = 1'b0;
                out_data_nxt.dropped_flag = ovf_r;
              end
              held_nxt.sel_start    = head.start;
              held_nxt.sel_duration = head.len;
              held_nxt.sel_finish   = head.fin;
              held_nxt.sel_position = sel_n_r[POS_W-1:0];
              held_nxt.end_of_run   = 1'b0;
              held_nxt.dropped_flag = 1'b0;
              held_v_nxt            = 1'b1;
              prev_fin_nxt          = head.fin;
              sel_n_nxt             = sel_n_r + SEL_CNT_W'(1);
            end
          end
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `ASEL_ASSERT_IMP(a_count_bound, 1'b1, count_r <= CW'(MAX_ACTIVITIES), "chain count over capacity")
  `ASEL_ASSERT_IMP(a_sel_bound, 1'b1, sel_n_r <= SEL_CNT_W'(RESULT_LIMIT), "too many picks")
  `ASEL_ASSERT_NXT(a_run_clear, (state_r == ST_SCAN) && out_free && scan_done, (count_r == '0) && !ovf_r && (state_r == ST_LOAD), "run end did not clear")
  `ASEL_ASSERT_NXT(a_drop_flag, (state_r == ST_LOAD) && in_valid && (count_r == CW'(MAX_ACTIVITIES)), ovf_r, "drop not flagged")

endmodule

`default_nettype wire
